/* rtl/pps_pkg.sv */
// Shared types for the payload power sequencer: sequence codes, tick and
// result payloads, and the architectural state record.
// No dependencies.
package pps_pkg;

    localparam int unsigned CountW = 16;
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [CountW-1:0] LongPressReset = 16'd20;

    // Payload sequence codes
    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_PGWAIT  = 3'd1,
        ST_SETUP   = 3'd2,
        ST_FPGA_ON = 3'd3,
        ST_OFF     = 3'd4,
        ST_QUIESC  = 3'd5
    } seq_state_t;

    typedef struct packed {
        logic main_power_ok;
        logic dcdc_good_event;
        logic dcdc_bad_event;
        logic quiesce_event;
        logic cold_reset_event;
        logic reboot_event;
        logic button_level;
        logic hotswap_ack;
    } tick_t;

    typedef struct packed {
        logic [2:0] payload_state;
        logic       dcdc_on_request;
        logic       dcdc_off_request;
        logic       fpga_reset_pulse;
        logic       long_press_seen;
        logic       fpga_program_pulse;
        logic       fpga_run_level;
        logic       hotswap_clear_backend;
        logic       hotswap_quiesce_request;
        logic       converters_ready;
    } result_t;

    typedef struct packed {
        seq_state_t          seq;
        logic                started;
        logic                conv_good;
        logic                quiesce_pending;
        logic                last_button;
        logic                press_lock;
        logic [CountW-1:0]   press_count;
        logic                run_level;
        logic                ready_flag;
    } seq_ctx_t;

endpackage

/* rtl/pps_ifs.sv */
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on pps_pkg.
interface pps_tick_if;
    import pps_pkg::*;

    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pps_result_if;
    import pps_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/pps_step.sv */
// Next-state and strobe logic for one tick of the payload sequencer.
// Depends on pps_pkg.
module pps_step (
    input  pps_pkg::seq_ctx_t          ctx,
    input  pps_pkg::tick_t             tick,
    input  logic [pps_pkg::CountW-1:0] long_press_ticks,
    output pps_pkg::seq_ctx_t          ctx_next,
    output pps_pkg::result_t           res
);
    import pps_pkg::*;

    always_comb
    begin
        seq_ctx_t   n;
        seq_state_t cur;
        seq_state_t nxt;
        logic       on_req;
        logic       off_req;
        logic       rst_pulse;
        logic       long_seen;
        logic       prog_pulse;
        logic       hs_clear;
        logic       hs_quiesce;

        n          = ctx;
        on_req     = 1'b0;
        off_req    = 1'b0;
        rst_pulse  = 1'b0;
        long_seen  = 1'b0;
        prog_pulse = 1'b0;
        hs_clear   = 1'b0;
        hs_quiesce = 1'b0;
        cur        = ctx.seq;
        nxt        = ctx.seq;

        // Arm on the first converter event
        if (tick.dcdc_good_event || tick.dcdc_bad_event)
        begin
            n.started = 1'b1;
        end

        if (n.started)
        begin
            // Track the button press duration
            if (!tick.button_level && ctx.last_button)
            begin
                n.press_count = '0;
                n.press_lock  = 1'b0;
            end
            else if (ctx.press_count != CountMax)
            begin
                n.press_count = ctx.press_count + 1'b1;
            end
            if ((n.press_count > long_press_ticks) && !n.press_lock && !tick.button_level)
            begin
                rst_pulse    = 1'b1;
                long_seen    = 1'b1;
                n.press_lock = 1'b1;
            end
            n.last_button = tick.button_level;

            // Fold in the events; a bad report wins
            if (tick.dcdc_good_event)
            begin
                n.conv_good = 1'b1;
            end
            if (tick.dcdc_bad_event)
            begin
                n.conv_good = 1'b0;
            end
            if (tick.quiesce_event)
            begin
                n.quiesce_pending = 1'b1;
            end
            if (tick.cold_reset_event)
            begin
                cur = ST_OFF;
            end
            if (tick.reboot_event)
            begin
                rst_pulse = 1'b1;
            end

            // Advance the sequence
            nxt = cur;
            unique case (cur)
                ST_NONE:
                begin
                    if (tick.main_power_ok)
                    begin
                        nxt = ST_PGWAIT;
                    end
                    n.quiesce_pending = 1'b0;
                end
                ST_PGWAIT:
                begin
                    on_req       = !n.conv_good;
                    n.ready_flag = 1'b1;
                    hs_clear     = 1'b1;
                    nxt          = ST_SETUP;
                end
                ST_SETUP:
                begin
                    if (n.quiesce_pending || !tick.main_power_ok)
                    begin
                        nxt = ST_OFF;
                    end
                    else if (n.conv_good)
                    begin
                        nxt         = ST_FPGA_ON;
                        n.run_level = 1'b1;
                        prog_pulse  = 1'b1;
                    end
                end
                ST_FPGA_ON:
                begin
                    if (n.quiesce_pending || !tick.main_power_ok || !n.conv_good)
                    begin
                        nxt = ST_OFF;
                    end
                end
                ST_OFF:
                begin
                    n.run_level  = 1'b0;
                    n.ready_flag = 1'b0;
                    off_req      = 1'b1;
                    if (n.quiesce_pending)
                    begin
                        hs_quiesce = 1'b1;
                        if (tick.hotswap_ack)
                        begin
                            n.quiesce_pending = 1'b0;
                            nxt               = ST_QUIESC;
                        end
                    end
                    else
                    begin
                        nxt = ST_QUIESC;
                    end
                end
                ST_QUIESC:
                begin
                    if (!tick.main_power_ok)
                    begin
                        nxt = ST_NONE;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
            n.seq = nxt;
        end

        ctx_next = n;

        res.payload_state           = n.seq;
        res.dcdc_on_request         = on_req;
        res.dcdc_off_request        = off_req;
        res.fpga_reset_pulse        = rst_pulse;
        res.long_press_seen         = long_seen;
        res.fpga_program_pulse      = prog_pulse;
        res.fpga_run_level          = n.run_level;
        res.hotswap_clear_backend   = hs_clear;
        res.hotswap_quiesce_request = hs_quiesce;
        res.converters_ready        = n.ready_flag;
    end

endmodule

/* rtl/payload_power_sequencer.sv */
// Top level of the payload power sequencer: tick input register, sequence
// state, result register and the long-press threshold register.
// Depends on pps_pkg, pps_ifs (pps_tick_if, pps_result_if) and pps_step.
//
//   port      dir   handshake     carries
//   tick      in    valid/ready   one control tick (tick_t)
//   result    out   valid/ready   state and strobes for that tick (result_t)
//   cfg_wr_*  in    write enable  long_press_ticks, 16 bits
//
// A tick is held in the input register, then passes the step logic into
// the result register. A new tick is taken every cycle while the result
// is not stalled; the sequence state updates as a tick moves from the
// input register into the result register.
// A stalled result holds both registers; the input side fills and then drops
// ready. Reset clears the sequence state and sets the threshold to 20.
module payload_power_sequencer (
    input  logic                       clk,
    input  logic                       rst_n,
    pps_tick_if.sink                   tick,
    pps_result_if.source               result,
    input  logic                       cfg_wr_en,
    input  logic [pps_pkg::CountW-1:0] cfg_wr_data
);
    import pps_pkg::*;

    logic              in_valid_reg;
    tick_t             in_data_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    seq_ctx_t          ctx_reg;
    seq_ctx_t          ctx_next;
    result_t           res_next;
    logic [CountW-1:0] long_press_reg;
    logic              advance;

    // Move the held tick forward when the result slot is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    pps_step u_step (
        .ctx              (ctx_reg),
        .tick             (in_data_reg),
        .long_press_ticks (long_press_reg),
        .ctx_next         (ctx_next),
        .res              (res_next)
    );

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LongPressReset;
        end
        else if (cfg_wr_en)
        begin
            long_press_reg <= cfg_wr_data;
        end
    end

    // Capture a tick on transfer, drop it once it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.valid && tick.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_data_reg <= tick.data;
        end
    end

    // Update the sequence state on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.seq             <= ST_NONE;
            ctx_reg.started         <= 1'b0;
            ctx_reg.conv_good       <= 1'b0;
            ctx_reg.quiesce_pending <= 1'b0;
            ctx_reg.last_button     <= 1'b1;
            ctx_reg.press_lock      <= 1'b0;
            ctx_reg.press_count     <= '0;
            ctx_reg.run_level       <= 1'b0;
            ctx_reg.ready_flag      <= 1'b0;
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Load the result register, clear it once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res_next;
        end
    end

    // Input ready is low only while a tick is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> in_valid_reg)
        else $error("tick ready low with empty input register");

    // An advancing tick always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick lost before result register");

    // Once armed, the sequencer stays armed
    assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.started |=> ctx_reg.started)
        else $error("start flag dropped");

    // The FPGA run level is only held in fpga on or while switching off
    assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.run_level |-> (ctx_reg.seq == ST_FPGA_ON || ctx_reg.seq == ST_OFF))
        else $error("run level held outside fpga on");

    // A held tick does not advance while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule
